// ===== design/pmo_pkg.sv =====
package pmo_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_COORD_BITS = 16;
    localparam int DEF_INDEX_BITS = 16;

    // Offset width register
    localparam int               CFG_W       = 12;
    localparam logic [CFG_W-1:0] WIDTH_RESET = 12'd80;

    // Fixed-point scales
    localparam int UNIT_FRAC  = 14;   // unit vectors
    localparam int LEN_FRAC   = 8;    // vector length from the square root
    localparam int NORM_SHIFT = 16;   // vectors at or above 2^16 get halved before normalizing

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_EDGE,
        S_CR1,
        S_CR2,
        S_N1,
        S_N2,
        S_UV_CHK,
        S_UV_HALF,
        S_UV_SQ1,
        S_UV_SQ2,
        S_SQRT,
        S_UV_DX,
        S_UV_DY,
        S_UV_END,
        S_DIV,
        S_MID,
        S_CVX_X,
        S_CVX_Y,
        S_DOT1,
        S_DOT2,
        S_DOT_CHK,
        S_CC_X1,
        S_CC_X2,
        S_CC_Y1,
        S_CC_Y2,
        S_CC_END,
        S_FIN,
        S_OUT,
        S_UPD
    } state_t;

    // Which vector the normalize routine is working on
    typedef enum logic [1:0] {
        UV_N1,
        UV_N2,
        UV_MID
    } uv_sel_t;

    // Corner of the current input vertex
    typedef enum logic [1:0] {
        CRN_PREV,
        CRN_LAST,
        CRN_CLOSE
    } corner_t;

endpackage

// ===== design/polygon_miter_offset.sv =====
// Polygon miter offset.
// Slave stream: one polygon vertex per beat. s_axis_tdata holds vertex_x
// (low half) and vertex_y (high half); s_axis_tlast marks the closing vertex.
// Master stream: one offset point per beat with its vertex index, the convex
// and degenerate flags in m_axis_tuser, and m_axis_tlast on the result for
// vertex 0 that closes the polygon.
// Vertex k is emitted when vertex k+1 arrives; the last vertex also emits
// itself and then vertex 0. Polygons of fewer than three vertices give nothing.
// The user writes the offset width via cfg_wr_en / cfg_wr_data only while idle; not enforced.
// One multiplier, one radix-2 restoring divider and one bit-pair square root
// unit are shared under a sequencer. Per corner: the edge and normal steps, up to
// three normalizations (each a square root and two divisions of DW bits, DW is
// 64 at the default parameters), and at a concave corner that is not degenerate
// two more divisions. The first two vertices of a polygon have no corners, the
// closing vertex three.
// s_axis_tready is high only while the sequencer is idle, so one vertex is in
// flight at a time. A result waits in the output register until m_axis_tready;
// the sequencer holds meanwhile. Reset clears the vertex history, the count
// and the sequencer and loads the offset width with 80 (80 coordinate units).
module polygon_miter_offset
    import pmo_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int INDEX_BITS = DEF_INDEX_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_W-1:0]       cfg_wr_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // vertex_x, vertex_y
    input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // vertex_index, offset_x, offset_y
    output logic [((INDEX_BITS+2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    // is_convex, degenerate
    output logic [1:0]             m_axis_tuser,
    output logic                   m_axis_tlast
);

    localparam int ODW  = ((INDEX_BITS+2*COORD_BITS+7)/8)*8;
    localparam int EW   = COORD_BITS + 1;
    localparam int MW   = (EW > 19) ? EW : 19;
    localparam int PW   = 2 * MW;
    localparam int DW   = (PW + 2 > 64) ? PW + 2 : 64;
    localparam int CW   = $clog2(DW);
    localparam int SW   = DW / 2;
    localparam int SCW  = $clog2(SW);
    localparam int NORM_LIM = 1 << NORM_SHIFT;

    localparam logic signed [MW-1:0] NORM_POS = MW'(NORM_LIM);
    localparam logic signed [MW-1:0] NORM_NEG = -MW'(NORM_LIM);
    localparam logic signed [DW-1:0] SAT_HI   = (DW'(1) << (COORD_BITS - 1)) - DW'(1);
    localparam logic signed [DW-1:0] SAT_LO   = -SAT_HI - DW'(1);
    localparam logic signed [DW-1:0] F_ONE    = DW'(1) << (2 * UNIT_FRAC);
    localparam logic [DW-1:0]        RND_HALF = DW'(1) << (UNIT_FRAC - 1);
    localparam logic [INDEX_BITS-1:0] CNT_MAX = '1;

    state_t  state_reg, state_next, ret_reg;
    uv_sel_t uv_sel_reg;
    corner_t crn_reg;

    logic [CFG_W-1:0]             width_reg;
    logic [INDEX_BITS-1:0]        cnt_reg;
    logic signed [COORD_BITS-1:0] rec_x_reg [2];
    logic signed [COORD_BITS-1:0] rec_y_reg [2];
    logic signed [COORD_BITS-1:0] opn_x_reg [2];
    logic signed [COORD_BITS-1:0] opn_y_reg [2];
    logic signed [COORD_BITS-1:0] pin_x_reg, pin_y_reg;
    logic                         last_reg;

    logic signed [COORD_BITS-1:0] bx_reg, by_reg;
    logic signed [EW-1:0]         e1x_reg, e1y_reg, e2x_reg, e2y_reg;
    logic                         convex_reg, degen_reg;
    logic signed [MW-1:0]         vx_reg, vy_reg, ux_reg, uy_reg;
    logic signed [MW-1:0]         n1x_reg, n1y_reg, n2x_reg, n2y_reg;
    logic signed [DW-1:0]         acc_reg, f_reg, ox_reg, oy_reg;
    logic [DW-1:0]                len_reg;

    logic [DW-1:0]                num_reg, den_reg, quo_reg;
    logic [DW:0]                  rem_reg;
    logic [CW-1:0]                dcnt_reg;
    logic                         dneg_reg;

    logic [DW-1:0]                sv_reg, sr_reg;
    logic [SCW-1:0]               scnt_reg;

    logic [INDEX_BITS-1:0]        o_idx_reg;
    logic [COORD_BITS-1:0]        o_x_reg, o_y_reg;
    logic                         o_cvx_reg, o_deg_reg, o_last_reg;

    // Corner points
    logic signed [COORD_BITS-1:0] ax, ay, bx, by, cx, cy;

    always_comb
    begin
        unique case (crn_reg)
            CRN_PREV:
            begin
                ax = rec_x_reg[1]; ay = rec_y_reg[1];
                bx = rec_x_reg[0]; by = rec_y_reg[0];
                cx = pin_x_reg;    cy = pin_y_reg;
            end
            CRN_LAST:
            begin
                ax = rec_x_reg[0]; ay = rec_y_reg[0];
                bx = pin_x_reg;    by = pin_y_reg;
                cx = opn_x_reg[0]; cy = opn_y_reg[0];
            end
            default:
            begin
                ax = pin_x_reg;    ay = pin_y_reg;
                bx = opn_x_reg[0]; by = opn_y_reg[0];
                cx = opn_x_reg[1]; cy = opn_y_reg[1];
            end
        endcase
    end

    // Shared multiplier
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod;
    logic signed [DW-1:0] prod_ext;
    logic signed [MW-1:0] w_s;

    assign w_s = MW'($signed({1'b0, width_reg}));

    always_comb
    begin
        unique case (state_reg)
            S_CR1:    begin mul_a = MW'(e1x_reg); mul_b = MW'(e2y_reg); end
            S_CR2:    begin mul_a = MW'(e1y_reg); mul_b = MW'(e2x_reg); end
            S_UV_SQ1: begin mul_a = vx_reg;       mul_b = vx_reg;       end
            S_UV_SQ2: begin mul_a = vy_reg;       mul_b = vy_reg;       end
            S_CVX_X:  begin mul_a = ux_reg;       mul_b = w_s;          end
            S_CVX_Y:  begin mul_a = uy_reg;       mul_b = w_s;          end
            S_DOT1:   begin mul_a = n1x_reg;      mul_b = n2x_reg;      end
            S_DOT2:   begin mul_a = n1y_reg;      mul_b = n2y_reg;      end
            S_CC_X1:  begin mul_a = vx_reg;       mul_b = w_s;          end
            S_CC_Y1:  begin mul_a = vy_reg;       mul_b = w_s;          end
            default:  begin mul_a = '0;           mul_b = '0;           end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign prod_ext = DW'(prod);

    // Round product / 2^UNIT_FRAC half away from zero
    logic [DW-1:0]        prod_mag, rnd_mag;
    logic signed [DW-1:0] rnd_val;

    assign prod_mag = (prod_ext < 0) ? DW'(-prod_ext) : DW'(prod_ext);
    assign rnd_mag  = (prod_mag + RND_HALF) >> UNIT_FRAC;
    assign rnd_val  = (prod_ext < 0) ? -$signed(rnd_mag) : $signed(rnd_mag);

    // Divider and square root steps
    logic [DW:0]          trial;
    logic                 trial_ok;
    logic signed [DW-1:0] div_res;
    logic [DW-1:0]        sbit, sr_bit;
    logic                 sq_ok;

    assign trial    = {rem_reg[DW-1:0], num_reg[DW-1]};
    assign trial_ok = trial >= {1'b0, den_reg};
    assign div_res  = dneg_reg ? -$signed(quo_reg) : $signed(quo_reg);
    assign sbit     = DW'(1) << {scnt_reg, 1'b0};
    assign sr_bit   = sr_reg + sbit;
    assign sq_ok    = sv_reg >= sr_bit;

    // Operands for division starts
    logic signed [DW-1:0] vx_e, vy_e, acc_abs;
    logic [DW-1:0]        vx_abs, vy_abs;

    assign vx_e    = DW'(vx_reg);
    assign vy_e    = DW'(vy_reg);
    assign vx_abs  = (vx_e < 0) ? DW'(-vx_e) : DW'(vx_e);
    assign vy_abs  = (vy_e < 0) ? DW'(-vy_e) : DW'(vy_e);
    assign acc_abs = (acc_reg < 0) ? -acc_reg : acc_reg;

    logic uv_zero, uv_big;

    assign uv_zero = (vx_reg == '0) && (vy_reg == '0);
    assign uv_big  = (vx_reg >= NORM_POS) || (vx_reg <= NORM_NEG)
                     || (vy_reg >= NORM_POS) || (vy_reg <= NORM_NEG);

    // Final sum and saturation
    logic signed [DW-1:0] sum_x, sum_y;
    logic [COORD_BITS-1:0] sat_x, sat_y;

    assign sum_x = DW'(bx_reg) + ox_reg;
    assign sum_y = DW'(by_reg) + oy_reg;
    assign sat_x = (sum_x > SAT_HI) ? SAT_HI[COORD_BITS-1:0]
                 : (sum_x < SAT_LO) ? SAT_LO[COORD_BITS-1:0] : sum_x[COORD_BITS-1:0];
    assign sat_y = (sum_y > SAT_HI) ? SAT_HI[COORD_BITS-1:0]
                 : (sum_y < SAT_LO) ? SAT_LO[COORD_BITS-1:0] : sum_y[COORD_BITS-1:0];

    logic s_fire;
    assign s_fire = s_axis_tvalid && s_axis_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (s_axis_tvalid) state_next = (cnt_reg >= INDEX_BITS'(2)) ? S_EDGE : S_UPD;
            S_EDGE:    state_next = S_CR1;
            S_CR1:     state_next = S_CR2;
            S_CR2:     state_next = S_N1;
            S_N1:      state_next = S_UV_CHK;
            S_N2:      state_next = S_UV_CHK;
            S_UV_CHK:
            begin
                priority if (uv_zero) state_next = S_FIN;
                else if (uv_big)      state_next = S_UV_HALF;
                else                  state_next = S_UV_SQ1;
            end
            S_UV_HALF: state_next = S_UV_CHK;
            S_UV_SQ1:  state_next = S_UV_SQ2;
            S_UV_SQ2:  state_next = S_SQRT;
            S_SQRT:    if (scnt_reg == '0) state_next = S_UV_DX;
            S_UV_DX:   state_next = S_DIV;
            S_UV_DY:   state_next = S_DIV;
            S_UV_END:
            begin
                unique case (uv_sel_reg)
                    UV_N1:   state_next = S_N2;
                    UV_N2:   state_next = S_MID;
                    default: state_next = S_CVX_X;
                endcase
            end
            S_DIV:     if (dcnt_reg == '0) state_next = ret_reg;
            S_MID:     state_next = convex_reg ? S_UV_CHK : S_DOT1;
            S_CVX_X:   state_next = S_CVX_Y;
            S_CVX_Y:   state_next = S_FIN;
            S_DOT1:    state_next = S_DOT2;
            S_DOT2:    state_next = S_DOT_CHK;
            S_DOT_CHK: state_next = (f_reg <= 0) ? S_FIN : S_CC_X1;
            S_CC_X1:   state_next = S_CC_X2;
            S_CC_X2:   state_next = S_DIV;
            S_CC_Y1:   state_next = S_CC_Y2;
            S_CC_Y2:   state_next = S_DIV;
            S_CC_END:  state_next = S_FIN;
            S_FIN:     state_next = S_OUT;
            S_OUT:
            begin
                if (m_axis_tready)
                    state_next = (last_reg && crn_reg != CRN_CLOSE) ? S_EDGE : S_UPD;
            end
            S_UPD:     state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        s_axis_tready = (state_reg == S_IDLE);
        m_axis_tvalid = (state_reg == S_OUT);
        m_axis_tdata  = ODW'({o_y_reg, o_x_reg, o_idx_reg});
        m_axis_tuser  = {o_deg_reg, o_cvx_reg};
        m_axis_tlast  = o_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            width_reg <= WIDTH_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
                width_reg <= cfg_wr_data;
        end
    end

    // Vertex history and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            last_reg  <= 1'b0;
            crn_reg   <= CRN_PREV;
            for (int i = 0; i < 2; i++)
            begin
                rec_x_reg[i] <= '0;
                rec_y_reg[i] <= '0;
                opn_x_reg[i] <= '0;
                opn_y_reg[i] <= '0;
            end
        end
        else
        begin
            if (s_fire)
            begin
                last_reg <= s_axis_tlast;
                crn_reg  <= CRN_PREV;
            end
            if (state_reg == S_OUT && m_axis_tready && last_reg)
                crn_reg <= (crn_reg == CRN_PREV) ? CRN_LAST : CRN_CLOSE;
            if (state_reg == S_UPD)
            begin
                if (last_reg)
                begin
                    cnt_reg <= '0;
                    for (int i = 0; i < 2; i++)
                    begin
                        rec_x_reg[i] <= '0;
                        rec_y_reg[i] <= '0;
                        opn_x_reg[i] <= '0;
                        opn_y_reg[i] <= '0;
                    end
                end
                else
                begin
                    rec_x_reg[1] <= rec_x_reg[0];
                    rec_y_reg[1] <= rec_y_reg[0];
                    rec_x_reg[0] <= pin_x_reg;
                    rec_y_reg[0] <= pin_y_reg;
                    if (cnt_reg < INDEX_BITS'(2))
                    begin
                        opn_x_reg[cnt_reg[0]] <= pin_x_reg;
                        opn_y_reg[cnt_reg[0]] <= pin_y_reg;
                    end
                    if (cnt_reg != CNT_MAX)
                        cnt_reg <= cnt_reg + INDEX_BITS'(1);
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            pin_x_reg <= s_axis_tdata[COORD_BITS-1:0];
            pin_y_reg <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
        end
        unique case (state_reg)
            S_EDGE:
            begin
                bx_reg    <= bx;
                by_reg    <= by;
                e1x_reg   <= EW'(ax) - EW'(bx);
                e1y_reg   <= EW'(ay) - EW'(by);
                e2x_reg   <= EW'(bx) - EW'(cx);
                e2y_reg   <= EW'(by) - EW'(cy);
                degen_reg <= 1'b0;
                ox_reg    <= '0;
                oy_reg    <= '0;
            end
            S_CR1: acc_reg <= prod_ext;
            S_CR2: convex_reg <= acc_reg > prod_ext;
            S_N1:
            begin
                vx_reg     <= -MW'(e1y_reg);
                vy_reg     <= MW'(e1x_reg);
                uv_sel_reg <= UV_N1;
            end
            S_N2:
            begin
                vx_reg     <= -MW'(e2y_reg);
                vy_reg     <= MW'(e2x_reg);
                uv_sel_reg <= UV_N2;
            end
            S_UV_CHK:
            begin
                if (uv_zero)
                begin
                    degen_reg <= 1'b1;
                    ox_reg    <= '0;
                    oy_reg    <= '0;
                end
            end
            S_UV_HALF:
            begin
                // truncate toward zero
                vx_reg <= (vx_reg + $signed(MW'(vx_reg < 0))) >>> 1;
                vy_reg <= (vy_reg + $signed(MW'(vy_reg < 0))) >>> 1;
            end
            S_UV_SQ1: acc_reg <= prod_ext;
            S_UV_SQ2:
            begin
                sv_reg   <= DW'(acc_reg + prod_ext) << (2 * LEN_FRAC);
                sr_reg   <= '0;
                scnt_reg <= SCW'(SW - 1);
            end
            S_SQRT:
            begin
                if (sq_ok)
                begin
                    sv_reg <= sv_reg - sr_bit;
                    sr_reg <= (sr_reg >> 1) + sbit;
                end
                else
                    sr_reg <= sr_reg >> 1;
                scnt_reg <= scnt_reg - SCW'(1);
            end
            S_UV_DX:
            begin
                len_reg  <= sr_reg;
                num_reg  <= (vx_abs << (UNIT_FRAC + LEN_FRAC)) + (sr_reg >> 1);
                den_reg  <= sr_reg;
                dneg_reg <= vx_e < 0;
                rem_reg  <= '0;
                quo_reg  <= '0;
                dcnt_reg <= CW'(DW - 1);
                ret_reg  <= S_UV_DY;
            end
            S_UV_DY:
            begin
                ux_reg   <= div_res[MW-1:0];
                num_reg  <= (vy_abs << (UNIT_FRAC + LEN_FRAC)) + (len_reg >> 1);
                den_reg  <= len_reg;
                dneg_reg <= vy_e < 0;
                rem_reg  <= '0;
                quo_reg  <= '0;
                dcnt_reg <= CW'(DW - 1);
                ret_reg  <= S_UV_END;
            end
            S_UV_END:
            begin
                unique case (uv_sel_reg)
                    UV_N1:
                    begin
                        n1x_reg <= ux_reg;
                        n1y_reg <= div_res[MW-1:0];
                    end
                    UV_N2:
                    begin
                        n2x_reg <= ux_reg;
                        n2y_reg <= div_res[MW-1:0];
                    end
                    default: uy_reg <= div_res[MW-1:0];
                endcase
            end
            S_DIV:
            begin
                if (trial_ok)
                begin
                    rem_reg <= trial - {1'b0, den_reg};
                    quo_reg <= {quo_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[DW-2:0], 1'b0};
                end
                num_reg  <= num_reg << 1;
                dcnt_reg <= dcnt_reg - CW'(1);
            end
            S_MID:
            begin
                vx_reg     <= n1x_reg + n2x_reg;
                vy_reg     <= n1y_reg + n2y_reg;
                uv_sel_reg <= UV_MID;
            end
            S_CVX_X: ox_reg <= rnd_val;
            S_CVX_Y: oy_reg <= rnd_val;
            S_DOT1:  f_reg  <= F_ONE + prod_ext;
            S_DOT2:  f_reg  <= f_reg + prod_ext;
            S_DOT_CHK:
            begin
                if (f_reg <= 0)
                begin
                    degen_reg <= 1'b1;
                    ox_reg    <= '0;
                    oy_reg    <= '0;
                end
            end
            S_CC_X1: acc_reg <= prod_ext;
            S_CC_X2, S_CC_Y2:
            begin
                num_reg  <= (DW'(acc_abs) << UNIT_FRAC) + DW'(f_reg >>> 1);
                den_reg  <= DW'(f_reg);
                dneg_reg <= acc_reg < 0;
                rem_reg  <= '0;
                quo_reg  <= '0;
                dcnt_reg <= CW'(DW - 1);
                ret_reg  <= (state_reg == S_CC_X2) ? S_CC_Y1 : S_CC_END;
            end
            S_CC_Y1:
            begin
                ox_reg  <= div_res;
                acc_reg <= prod_ext;
            end
            S_CC_END: oy_reg <= div_res;
            S_FIN:
            begin
                unique case (crn_reg)
                    CRN_PREV: o_idx_reg <= cnt_reg - INDEX_BITS'(1);
                    CRN_LAST: o_idx_reg <= cnt_reg;
                    default:  o_idx_reg <= '0;
                endcase
                o_x_reg    <= degen_reg ? bx_reg : sat_x;
                o_y_reg    <= degen_reg ? by_reg : sat_y;
                o_cvx_reg  <= convex_reg;
                o_deg_reg  <= degen_reg;
                o_last_reg <= (crn_reg == CRN_CLOSE);
            end
            default: ;
        endcase
    end

    // The two sides never handshake in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input accepted while a result is pending");

    // The closing result always belongs to vertex 0
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[INDEX_BITS-1:0] == '0))
        else $error("closing result with nonzero vertex index");

    // Divisions only run on a nonzero divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (den_reg != '0))
        else $error("division by zero in sequencer");

    // An accepted vertex always starts the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> (state_reg == S_EDGE || state_reg == S_UPD))
        else $error("accepted vertex did not start work");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

class miter_scoreboard;
    typedef struct {
        logic [15:0] index;
        logic [15:0] ox;
        logic [15:0] oy;
        logic        convex;
        logic        degen;
        logic        last;
    } offset_pt_t;

    offset_pt_t  pending[$];
    int          errors;
    longint      width;
    longint      prev_x[2];
    longint      prev_y[2];
    longint      open_x[2];
    longint      open_y[2];
    longint      count;

    function new();
        errors = 0;
        width  = 80;
        clear_polygon();
    endfunction

    function void clear_polygon();
        prev_x = '{0, 0};
        prev_y = '{0, 0};
        open_x = '{0, 0};
        open_y = '{0, 0};
        count  = 0;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // round half away from zero, d > 0
    function longint round_div(longint n, longint d);
        if (n >= 0) return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function bit normalize(longint x, longint y, output longint ux, output longint uy);
        longint len;
        ux = 0;
        uy = 0;
        if (x == 0 && y == 0) return 0;
        while (x >= 65536 || x <= -65536 || y >= 65536 || y <= -65536) begin
            x = x / 2;
            y = y / 2;
        end
        len = longint'(int_sqrt(longint'(x * x + y * y) << 16));
        ux  = round_div(x * (longint'(1) << 22), len);
        uy  = round_div(y * (longint'(1) << 22), len);
        return 1;
    endfunction

    function void corner(longint ax, longint ay, longint bx, longint by,
                         longint cx, longint cy, longint idx, bit last);
        offset_pt_t p;
        longint e1x, e1y, e2x, e2y, cr, n1x, n1y, n2x, n2y, mx, my, ux, uy, f;
        longint ox, oy;
        bit cvx, dg;
        e1x = ax - bx;
        e1y = ay - by;
        e2x = bx - cx;
        e2y = by - cy;
        cr  = e1x * e2y - e1y * e2x;
        cvx = cr > 0;
        dg  = 0;
        ox  = 0;
        oy  = 0;
        if (!normalize(-e1y, e1x, n1x, n1y) || !normalize(-e2y, e2x, n2x, n2y)) begin
            dg = 1;
        end else begin
            mx = n1x + n2x;
            my = n1y + n2y;
            if (cvx) begin
                if (!normalize(mx, my, ux, uy)) dg = 1;
                else begin
                    ox = round_div(ux * width, longint'(1) << 14);
                    oy = round_div(uy * width, longint'(1) << 14);
                end
            end else begin
                f = (longint'(1) << 28) + n1x * n2x + n1y * n2y;
                if (f <= 0) dg = 1;
                else begin
                    ox = round_div(mx * width * (longint'(1) << 14), f);
                    oy = round_div(my * width * (longint'(1) << 14), f);
                end
            end
        end
        if (dg) begin
            ox = 0;
            oy = 0;
        end
        p.index  = idx[15:0];
        p.ox     = 16'(clamp16(bx + ox));
        p.oy     = 16'(clamp16(by + oy));
        p.convex = cvx;
        p.degen  = dg;
        p.last   = last;
        pending = {pending, p};
    endfunction

    function void note_vertex(logic [15:0] vx, logic [15:0] vy, logic is_last);
        longint x, y, c;
        x = longint'($signed(vx));
        y = longint'($signed(vy));
        c = count;
        if (c >= 2) corner(prev_x[1], prev_y[1], prev_x[0], prev_y[0], x, y, c - 1, 0);
        if (is_last) begin
            if (c >= 2) begin
                corner(prev_x[0], prev_y[0], x, y, open_x[0], open_y[0], c, 0);
                corner(x, y, open_x[0], open_y[0], open_x[1], open_y[1], 0, 1);
            end
            clear_polygon();
            return;
        end
        prev_x[1] = prev_x[0];
        prev_y[1] = prev_y[0];
        prev_x[0] = x;
        prev_y[0] = y;
        if (c < 2) begin
            open_x[c] = x;
            open_y[c] = y;
        end
        if (c < 65535) count = c + 1;
    endfunction

    function void check_point(logic [47:0] data, logic [1:0] user, logic tlast);
        offset_pt_t e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected offset point data=%h user=%b last=%b",
                     $time, data, user, tlast);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (data !== {e.oy, e.ox, e.index} || user !== {e.degen, e.convex}
            || tlast !== e.last) begin
            $display("%0t: mismatch expected idx=%0d ox=%h oy=%h cvx=%b dg=%b last=%b",
                     $time, e.index, e.ox, e.oy, e.convex, e.degen, e.last);
            $display("%0t:          actual   idx=%0d ox=%h oy=%h cvx=%b dg=%b last=%b",
                     $time, data[15:0], data[31:16], data[47:32], user[0], user[1], tlast);
            errors++;
        end
    endfunction
endclass

module tb;
    import pmo_pkg::*;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               cfg_wr_en = 0;
    logic [CFG_W-1:0]   cfg_wr_data = '0;
    logic               s_axis_tvalid = 0;
    logic               s_axis_tready;
    logic [31:0]        s_axis_tdata = '0;
    logic               s_axis_tlast = 0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 0;
    logic [47:0]        m_axis_tdata;
    logic [1:0]         m_axis_tuser;
    logic               m_axis_tlast;

    miter_scoreboard    offsets = new();
    bit                 vtx_fired = 0;
    bit                 pt_fired = 0;
    bit                 no_idle = 0;
    bit                 hold_req = 0;
    int                 hold_cycles = 0;

    polygon_miter_offset i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    always @(posedge clk)
    begin
        vtx_fired = s_axis_tvalid && s_axis_tready;
        pt_fired  = m_axis_tvalid && m_axis_tready;
        if (vtx_fired)
            offsets.note_vertex(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tlast);
        if (pt_fired)
            offsets.check_point(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    // receiver: random gap before each beat, long hold-off on request
    initial
    begin
        int gap;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_axis_tready = 0;
                while (hold_cycles < 6000)
                begin
                    @(negedge clk);
                    hold_cycles++;
                end
                hold_req = 0;
            end
            gap = no_idle ? 0 : $urandom_range(0, 13);
            repeat (gap)
            begin
                m_axis_tready = 0;
                @(negedge clk);
            end
            m_axis_tready = 1;
            do @(negedge clk); while (!pt_fired && !hold_req);
        end
    end

    task automatic send_vertex(logic [15:0] x, logic [15:0] y, logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        repeat (gap)
        begin
            s_axis_tvalid = 0;
            @(negedge clk);
        end
        s_axis_tdata  = {y, x};
        s_axis_tlast  = last;
        s_axis_tvalid = 1;
        do @(negedge clk); while (!vtx_fired);
    endtask

    // drain, then let any result-free vertex finish before touching the register
    task automatic set_width(logic [CFG_W-1:0] w);
        s_axis_tvalid = 0;
        while (offsets.pending.size() != 0) @(negedge clk);
        repeat (2500) @(negedge clk);
        cfg_wr_data = w;
        cfg_wr_en   = 1;
        @(negedge clk);
        cfg_wr_en   = 0;
        offsets.width = w;
    endtask

    function automatic logic [15:0] rand_coord(int mode);
        if (mode == 0) return 16'($signed($urandom_range(0, 4000)) - 2000);
        if (mode == 1) return 16'($urandom);
        return ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
    endfunction

    task automatic random_polygon(output int n);
        int mode;
        logic [15:0] x, y;
        n    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
        mode = $urandom_range(0, 9) < 7 ? 0 : ($urandom_range(0, 3) == 0 ? 2 : 1);
        for (int i = 0; i < n; i++)
        begin
            // repeat a vertex now and then for zero-length edges
            if (i == 0 || $urandom_range(0, 15) != 0)
            begin
                x = rand_coord(mode);
                y = rand_coord(mode);
            end
            send_vertex(x, y, i == n - 1);
        end
    endtask

    initial
    begin
        int items;
        int sent;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // convex square counterclockwise, then a clockwise triangle
        send_vertex(16'd0, 16'd0, 0);
        send_vertex(16'd160, 16'd0, 0);
        send_vertex(16'd160, 16'd160, 0);
        send_vertex(16'd0, 16'd160, 1);
        send_vertex(16'd0, 16'd0, 0);
        send_vertex(16'd0, 16'd160, 0);
        send_vertex(16'd160, 16'd160, 1);
        // short polygons
        send_vertex(16'd5, 16'd5, 1);
        send_vertex(16'd5, 16'd5, 0);
        send_vertex(16'd50, 16'd9, 1);
        // zero-length edge, collinear and reversing edges
        send_vertex(16'd10, 16'd10, 0);
        send_vertex(16'd10, 16'd10, 0);
        send_vertex(16'd40, 16'd10, 0);
        send_vertex(16'd80, 16'd10, 0);
        send_vertex(16'd20, 16'd10, 1);
        // coordinate extremes, saturating offsets
        send_vertex(16'h7fff, 16'h7fff, 0);
        send_vertex(16'h8000, 16'h7fff, 0);
        send_vertex(16'h8000, 16'h8000, 0);
        send_vertex(16'h7fff, 16'h8000, 1);

        set_width(12'd0);
        send_vertex(16'd0, 16'd0, 0);
        send_vertex(16'd300, 16'd20, 0);
        send_vertex(16'hff00, 16'd500, 1);
        set_width(12'hfff);
        send_vertex(16'd0, 16'd0, 0);
        send_vertex(16'd300, 16'd20, 0);
        send_vertex(16'd100, 16'd50, 0);
        send_vertex(16'hff00, 16'd500, 1);

        items = 0;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                1: set_width(12'($urandom_range(0, 4095)));
                2: set_width(12'hfff);
                3: set_width(12'd80);
                default: ;
            endcase
            no_idle = (phase == 2);
            if (phase == 1) hold_req = 1;
            while (items < (phase + 1) * 56)
            begin
                random_polygon(sent);
                items = items + sent;
            end
        end

        s_axis_tvalid = 0;
        while (offsets.pending.size() != 0) @(negedge clk);
        repeat (2500) @(negedge clk);
        if (offsets.errors == 0 && offsets.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #60_000_000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
design/pmo_pkg.sv
design/polygon_miter_offset.sv
tb/tb.sv
